// ===== rtl/ntp_offset_delay_compute_defines.svh =====
// assertion macros used by the checker file
`ifndef NTP_OFFSET_DELAY_COMPUTE_DEFINES_SVH
`define NTP_OFFSET_DELAY_COMPUTE_DEFINES_SVH

// condition implies consequence in the same cycle
`define NTPOD_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("ntpod assertion failed");

// condition implies consequence in the next cycle
`define NTPOD_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("ntpod assertion failed");

`endif

// ===== rtl/ntpod_pkg.sv =====
`default_nettype none

package ntpod_pkg;

  // result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // fraction bits of the 32.32 timestamp format
  localparam int FRAC_BITS = 32;
  // theta >>> 22 must fit in 32 bits signed: bits 63..53 are all sign
  localparam int MS_SHIFT     = 22;
  localparam int MS_RANGE_LSB = MS_SHIFT + 31;

  // microseconds per second and the seconds limit at or above which delay saturates
  localparam logic [19:0] US_PER_SEC  = 20'd1000000;
  localparam logic [31:0] US_HI_LIMIT = 32'd4295;

  // input beat as captured
  typedef struct packed {
    logic [7:0]  stratum;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic        has_request;
    logic [63:0] req_xmt;
  } in_t;

  // timestamp differences
  typedef struct packed {
    logic        reject;
    logic [63:0] d21;
    logic [63:0] d34;
    logic [63:0] d41;
    logic [63:0] d32;
  } diff_t;

  // offset and delay in 32.32
  typedef struct packed {
    logic        reject;
    logic [63:0] theta;
    logic [63:0] delta;
  } base_t;

  // scaled partial results
  typedef struct packed {
    logic        reject;
    logic [63:0] theta;
    logic        ms_sat;
    logic [31:0] ms_val;
    logic        us_sat;
    logic [32:0] hi_us;
    logic [19:0] lo_us;
  } scaled_t;

endpackage

`default_nettype wire

// ===== rtl/ntp_offset_delay_compute.sv =====
// throughput: one beat per cycle while out_ready stays high, set by a five-register pipeline
// (input, differences, offset/delay, scaling, output) with a ready chain
// reset: synchronous active-high rst clears all stage valid bits; payload is not reset
`default_nettype none

module ntp_offset_delay_compute (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  stratum,
  input  wire logic [63:0] origin_time,
  input  wire logic [63:0] server_receive,
  input  wire logic [63:0] server_transmit,
  input  wire logic [63:0] arrival_time,
  input  wire logic        has_request,
  input  wire logic [63:0] request_transmit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic signed [63:0] offset_ntp,
  output logic signed [31:0] offset_ms,
  output logic [31:0]      round_trip_us
);
  import ntpod_pkg::*;

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   adv;

  in_t     s0;
  diff_t   s1, s1_next;
  base_t   s2, s2_next;
  scaled_t s3, s3_next;

  logic        status_next;
  logic [63:0] offset_ntp_next;
  logic [31:0] offset_ms_next;
  logic [31:0] round_trip_us_next;

  logic [64:0] sum_x;
  logic [63:0] sum;
  logic [63:0] ms_prod;
  logic [51:0] lo_prod;
  logic [33:0] us_total;

  // ready chain: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NSTAGE] = out_ready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTAGE-1];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // differences and reply checks
  always_comb begin
    s1_next.reject = (s0.stratum == 8'd0) ||
                     (s0.t3[63:FRAC_BITS] == '0) ||
                     (s0.t3[FRAC_BITS-1:0] == '0) ||
                     (s0.has_request && (s0.req_xmt != s0.t1));
    s1_next.d21 = s0.t2 - s0.t1;
    s1_next.d34 = s0.t3 - s0.t4;
    s1_next.d41 = s0.t4 - s0.t1;
    s1_next.d32 = s0.t3 - s0.t2;
  end

  // offset with halving toward zero, and round-trip delay
  always_comb begin
    sum = s1.d21 + s1.d34;
    sum_x = {sum[63], sum} + {64'd0, sum[63]};
    s2_next.reject = s1.reject;
    s2_next.theta  = sum_x[64:1];
    s2_next.delta  = s1.d41 - s1.d32;
  end

  // scaling: 1000 = 1024 - 16 - 8, delay split into seconds and fraction
  always_comb begin
    ms_prod = (s2.theta << 10) - (s2.theta << 4) - (s2.theta << 3);
    lo_prod = {20'd0, s2.delta[FRAC_BITS-1:0]} * {32'd0, US_PER_SEC};
    s3_next.reject = s2.reject;
    s3_next.theta  = s2.theta;
    s3_next.ms_sat = !((&s2.theta[63:MS_RANGE_LSB]) || !(|s2.theta[63:MS_RANGE_LSB]));
    s3_next.ms_val = ms_prod[63:FRAC_BITS];
    s3_next.us_sat = s2.delta[63:FRAC_BITS] >= US_HI_LIMIT;
    s3_next.hi_us  = {20'd0, s2.delta[FRAC_BITS+12:FRAC_BITS]} * {13'd0, US_PER_SEC};
    s3_next.lo_us  = lo_prod[51:FRAC_BITS];
  end

  // saturation and rejected-reply zeroing
  always_comb begin
    us_total = {1'b0, s3.hi_us} + {14'd0, s3.lo_us};
    if (s3.reject) begin
      status_next        = STATUS_REJECT;
      offset_ntp_next    = '0;
      offset_ms_next     = '0;
      round_trip_us_next = '0;
    end else begin
      status_next     = STATUS_OK;
      offset_ntp_next = s3.theta;
      if (s3.ms_sat) begin
        offset_ms_next = s3.theta[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        offset_ms_next = s3.ms_val;
      end
      if (s3.us_sat || (us_total[33:32] != 2'd0)) begin
        round_trip_us_next = 32'hFFFF_FFFF;
      end else begin
        round_trip_us_next = us_total[31:0];
      end
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0.stratum     <= stratum;
      s0.t1          <= origin_time;
      s0.t2          <= server_receive;
      s0.t3          <= server_transmit;
      s0.t4          <= arrival_time;
      s0.has_request <= has_request;
      s0.req_xmt     <= request_transmit;
    end
    if (adv[1]) begin
      s1 <= s1_next;
    end
    if (adv[2]) begin
      s2 <= s2_next;
    end
    if (adv[3]) begin
      s3 <= s3_next;
    end
    if (adv[4]) begin
      status        <= status_next;
      offset_ntp    <= offset_ntp_next;
      offset_ms     <= offset_ms_next;
      round_trip_us <= round_trip_us_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ntpod_checker.sv =====
`default_nettype none
`include "ntp_offset_delay_compute_defines.svh"

module ntpod_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status,
  input wire logic [63:0] offset_ntp,
  input wire logic [31:0] offset_ms,
  input wire logic [31:0] round_trip_us
);
  import ntpod_pkg::*;

  // whole result beat as one vector
  logic [128:0] out_beat;
  assign out_beat = {status, offset_ntp, offset_ms, round_trip_us};

  // a stalled result beat holds
  `NTPOD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat))

  // a rejected reply carries all-zero results
  `NTPOD_ASSERT_NOW(a_reject_zero, clk, rst, out_valid && (status == STATUS_REJECT), out_beat[127:0] == '0)

  // an empty output stage means the whole pipeline can take a beat
  `NTPOD_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // millisecond offset has the sign of the 32.32 offset
  `NTPOD_ASSERT_NOW(a_ms_sign, clk, rst, out_valid && (status == STATUS_OK), offset_ms[31] == offset_ntp[63])

endmodule

bind ntp_offset_delay_compute ntpod_checker u_ntpod_checker (.*);

`default_nettype wire
